>>> rtl/bfha_pkg.sv
// Shared constants, codes and control types for the best-fit hole allocator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package bfha_pkg;

  localparam int NUM_HOLES    = 8;
  localparam int SIZE_BITS    = 16;
  localparam int IDX_W        = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;

  // Fixed field widths of the stream words
  localparam int HOLE_FIELD_W = 3;
  localparam int AMOUNT_W     = 16;
  localparam int PACK_W       = HOLE_FIELD_W + AMOUNT_W;
  localparam int TDATA_W      = ((PACK_W + 7) / 8) * 8;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;    // take the input word, write table on a load
    logic scan_step;  // examine one hole, advance the scan index
    logic finish;     // load output register, write back the chosen hole
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // scan index is on the last hole
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage

>>> rtl/bfha_ctrl.sv
// Allocator sequencer: accepts a word, scans holes on an allocate, then
// hands the result to the output register. Depends on bfha_pkg.
`timescale 1ns / 1ps

module bfha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_kind,
  input  bfha_pkg::sts_t sts,
  output bfha_pkg::cmd_t cmd
);
  import bfha_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_kind == REQ_ALLOC) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register has room
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bfha_dp.sv
// Datapath: hole-size table, best-fit scan compare, result register.
// Driven by bfha_ctrl commands. Depends on bfha_pkg.
`timescale 1ns / 1ps

module bfha_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bfha_pkg::cmd_t                    cmd,
  output bfha_pkg::sts_t                    sts,
  input  logic                              in_kind,
  input  logic [bfha_pkg::HOLE_FIELD_W-1:0] in_hole,
  input  logic [bfha_pkg::AMOUNT_W-1:0]     in_amount,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_granted,
  output logic [bfha_pkg::HOLE_FIELD_W-1:0] out_hole,
  output logic [bfha_pkg::AMOUNT_W-1:0]     out_remain
);
  import bfha_pkg::*;

  logic [SIZE_BITS-1:0]    holes_r [NUM_HOLES];
  logic                    is_alloc_r;
  logic [SIZE_BITS-1:0]    amt_r;
  logic [IDX_W-1:0]        cnt_r;
  logic                    found_r;
  logic [IDX_W-1:0]        best_r;
  logic [SIZE_BITS-1:0]    best_left_r;
  logic                    out_valid_r;
  logic                    out_granted_r;
  logic [HOLE_FIELD_W-1:0] out_hole_r;
  logic [AMOUNT_W-1:0]     out_remain_r;

  logic [SIZE_BITS-1:0]    size_rd;
  logic [SIZE_BITS-1:0]    left;
  logic                    fits;
  logic                    better;
  logic                    load_ok;
  logic                    grant;

  assign size_rd = holes_r[cnt_r];
  assign fits    = (size_rd >= amt_r);
  assign left    = size_rd - amt_r;
  assign better  = fits && (!found_r || (left < best_left_r));
  assign load_ok = (32'(in_hole) < 32'(NUM_HOLES));
  assign grant   = is_alloc_r && found_r;

  assign sts.scan_last = (cnt_r == IDX_W'(NUM_HOLES - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  // hole table: load writes at capture, allocate writes back at finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_HOLES; i++) begin
        holes_r[i] <= '0;
      end
    end else if (cmd.capture && (in_kind == REQ_LOAD) && load_ok) begin
      holes_r[IDX_W'(in_hole)] <= SIZE_BITS'(in_amount);
    end else if (cmd.finish && grant) begin
      holes_r[best_r] <= best_left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_alloc_r <= (in_kind == REQ_ALLOC);
      amt_r      <= SIZE_BITS'(in_amount);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.capture) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (better) begin
        found_r <= 1'b1;
      end
    end
  end

  // strict compare keeps the lowest index on equal leftovers
  always_ff @(posedge clk) begin
    if (cmd.scan_step && better) begin
      best_r      <= cnt_r;
      best_left_r <= left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_granted_r <= grant;
      out_hole_r    <= grant ? HOLE_FIELD_W'(best_r) : '0;
      out_remain_r  <= grant ? AMOUNT_W'(best_left_r) : '0;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_hole    = out_hole_r;
  assign out_remain  = out_remain_r;

endmodule

>>> rtl/best_fit_hole_allocator.sv
// Best-fit hole allocator: a load word sets one hole size; its result is
// loaded into the output register at the finish step, and the next word can
// enter only after that. An allocate word scans all NUM_HOLES holes, one per
// cycle, before its finish step, and the next word likewise waits for it.
// A result held by out_tready holds the next word before its finish step.
// Synchronous active-low reset clears the hole table to zero and empties the
// output register.
`timescale 1ns / 1ps

module best_fit_hole_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [2:0] hole_index, [18:3] amount, [23:19] zero
  input  logic [bfha_pkg::TDATA_W-1:0] in_tdata,
  // [0] req_type
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [2:0] chosen_hole, [18:3] remaining_size, [23:19] zero
  output logic [bfha_pkg::TDATA_W-1:0] out_tdata,
  // [0] granted
  output logic                         out_tuser
);
  import bfha_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  logic [HOLE_FIELD_W-1:0] out_hole;
  logic [AMOUNT_W-1:0]     out_remain;

  bfha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (in_tuser),
    .in_hole     (in_tdata[HOLE_FIELD_W-1:0]),
    .in_amount   (in_tdata[PACK_W-1:HOLE_FIELD_W]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_granted (out_tuser),
    .out_hole    (out_hole),
    .out_remain  (out_remain)
  );

  assign out_tdata = TDATA_W'({out_remain, out_hole});

  // an accepted word closes the input in the following cycle
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after accepting a word");

  // a refused request reports zero index and size
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("non-granted result carries nonzero data");

  // a new result appears only after a word was in flight
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a word in flight");

endmodule
